### rtl/core/bnt_pkg.sv
// bnt_pkg: shared types, character codes and status codes for the
// base-100 number record to text converter. No dependencies.
package bnt_pkg;

    localparam int MAX_RES    = 5;
    localparam int QUEUE_AW   = 3;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_POINT = 7'h2E;
    localparam logic [6:0] CH_NONE  = 7'h00;

    localparam logic [7:0] TYPE_NUMBER = 8'd2;
    localparam logic [7:0] NEG_TERM    = 8'd102;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_TYPE = 2'd1,
        ST_NO_TERM  = 2'd2,
        ST_BAD_LEN  = 2'd3
    } status_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic [7:0] repeat_res;
        logic       end_of_number;
        status_t    status;
    } res_t;

    typedef struct packed {
        logic [2:0]              cnt;
        res_t [MAX_RES-1:0]      item;
    } batch_t;

    function automatic res_t mk_res(input logic [6:0] ch, input logic [7:0] rep,
                                    input logic eon, input status_t st);
        res_t r;
        r.char_code     = ch;
        r.repeat_res    = rep;
        r.end_of_number = eon;
        r.status        = st;
        return r;
    endfunction

endpackage

### rtl/core/base100_number_record_to_text.sv
// base100_number_record_to_text: top level; input register, decode and
// result queue. Depends on bnt_pkg, bnt_decode and bnt_queue.
//
// Usage:
//   Input channel (in_valid/in_ready, byte_value, record_last) takes one
//   byte of a base-100 numeric record per transaction: type byte, length
//   byte, exponent byte, mantissa bytes, and for negatives a terminator.
//   Output channel (out_valid/out_ready) gives text runs: char_code repeated
//   repeat_res times, and one closing run per record with end_of_number set
//   and status holding the outcome (ok, bad type, no terminator, bad length).
//   Flow: a byte accepted into the input register is decoded into up to
//   five runs that are written into the result queue (eight entries), which
//   drains one run per cycle while out_ready is high, so the input takes one
//   byte per cycle while at most three runs wait, and the sustained rate is
//   set by the single-run output port: typically two runs per mantissa
//   byte. When the receiver stalls, the queue fills, the decode holds, and
//   in_ready drops once the input register is full.
//   Reset clears the record state, the queue and the input register.
module base100_number_record_to_text #(
    parameter int MAX_RECORD_BYTES = 23
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_value,
    input  logic       record_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] char_code,
    output logic [7:0] repeat_res,
    output logic       end_of_number,
    output logic [1:0] status
);

    logic       in_vld_reg, in_vld_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       room;
    logic       step;

    bnt_pkg::batch_t batch;
    bnt_pkg::res_t   head;

    assign step        = in_vld_reg && room;
    assign in_ready    = !in_vld_reg || step;
    assign in_vld_next = (in_valid && in_ready) || (in_vld_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_value;
            last_reg <= record_last;
        end
    end

    bnt_decode #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step),
        .byte_value (byte_reg),
        .record_last(last_reg),
        .batch      (batch)
    );

    bnt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (step),
        .batch   (batch),
        .rd_ready(out_ready),
        .rd_valid(out_valid),
        .rd_data (head),
        .room    (room)
    );

    assign char_code     = head.char_code;
    assign repeat_res    = head.repeat_res;
    assign end_of_number = head.end_of_number;
    assign status        = head.status;

endmodule

### rtl/core/bnt_decode.sv
// bnt_decode: record state registers and the per-byte decode that turns one
// record byte into up to five text runs. Depends on bnt_pkg.
module bnt_decode #(
    parameter int MAX_RECORD_BYTES = 23
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  logic [7:0]      byte_value,
    input  logic            record_last,
    output bnt_pkg::batch_t batch
);

    localparam logic [7:0] LEN_MAX = 8'(MAX_RECORD_BYTES - 2);

    logic [4:0] pos_reg, pos_next;
    logic [4:0] len_reg, len_next;
    logic       neg_reg, neg_next;
    logic [7:0] exp_reg, exp_next;
    logic       failed_reg, failed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            neg_reg    <= 1'b0;
            exp_reg    <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            neg_reg    <= neg_next;
            exp_reg    <= exp_next;
            failed_reg <= failed_next;
        end
    end

    always_comb
    begin
        logic              neg_b;
        logic signed [8:0] e_new;
        logic signed [8:0] e_cur;
        logic signed [8:0] idx;
        logic signed [8:0] ndig;
        logic signed [8:0] dig;
        logic signed [8:0] rl;
        logic signed [8:0] rt;
        logic [6:0]        dig_c;
        logic [13:0]       prod;
        logic [3:0]        tens;
        logic [6:0]        u7;
        logic [3:0]        units;
        logic [2:0]        n;
        logic              fin;
        bnt_pkg::status_t  fst;

        pos_next    = pos_reg;
        len_next    = len_reg;
        neg_next    = neg_reg;
        exp_next    = exp_reg;
        failed_next = failed_reg;
        batch       = '0;
        n           = '0;
        fin         = 1'b0;
        fst         = bnt_pkg::ST_OK;

        neg_b = ~byte_value[7];
        e_new = neg_b ? (9'sd62 - $signed({1'b0, byte_value}))
                      : ($signed({1'b0, byte_value}) - 9'sd193);
        e_cur = $signed({exp_reg[7], exp_reg});
        idx   = $signed({4'b0, pos_reg}) - 9'sd3;
        ndig  = neg_reg ? ($signed({4'b0, len_reg}) - 9'sd2)
                        : ($signed({4'b0, len_reg}) - 9'sd1);
        dig   = neg_reg ? (9'sd101 - $signed({1'b0, byte_value}))
                        : ($signed({1'b0, byte_value}) - 9'sd1);
        if (dig < 9'sd0)
            dig_c = 7'd0;
        else if (dig > 9'sd99)
            dig_c = 7'd99;
        else
            dig_c = dig[6:0];
        prod  = {7'b0, dig_c} * 14'd103;
        tens  = prod[13:10];
        u7    = dig_c - 7'({3'b0, tens} * 7'd10);
        units = u7[3:0];
        rl    = -9'sd1 - e_new;
        rt    = e_cur - idx;

        if (step_en)
        begin
            if (failed_reg)
            begin
                if (record_last)
                begin
                    pos_next    = '0;
                    len_next    = '0;
                    neg_next    = 1'b0;
                    exp_next    = '0;
                    failed_next = 1'b0;
                end
            end
            else
            begin
                case (pos_reg)
                    5'd0:
                    begin
                        if (byte_value != bnt_pkg::TYPE_NUMBER)
                        begin
                            fin = 1'b1;
                            fst = bnt_pkg::ST_BAD_TYPE;
                        end
                        else if (record_last)
                        begin
                            fin = 1'b1;
                            fst = bnt_pkg::ST_BAD_LEN;
                        end
                        else
                            pos_next = 5'd1;
                    end
                    5'd1:
                    begin
                        if (byte_value == 8'd0 || byte_value > LEN_MAX || record_last)
                        begin
                            fin = 1'b1;
                            fst = bnt_pkg::ST_BAD_LEN;
                        end
                        else
                        begin
                            len_next = byte_value[4:0];
                            pos_next = 5'd2;
                        end
                    end
                    5'd2:
                    begin
                        if (neg_b && len_reg < 5'd3)
                        begin
                            fin = 1'b1;
                            fst = bnt_pkg::ST_BAD_LEN;
                        end
                        else
                        begin
                            neg_next = neg_b;
                            exp_next = e_new[7:0];
                            if (!neg_b && len_reg == 5'd1)
                            begin
                                batch.item[n] = bnt_pkg::mk_res(bnt_pkg::CH_ZERO, 8'd1, 1'b0,
                                                                bnt_pkg::ST_OK);
                                n   = n + 3'd1;
                                fin = 1'b1;
                                fst = record_last ? bnt_pkg::ST_OK : bnt_pkg::ST_BAD_LEN;
                            end
                            else if (record_last)
                            begin
                                fin = 1'b1;
                                fst = bnt_pkg::ST_BAD_LEN;
                            end
                            else
                            begin
                                if (neg_b)
                                begin
                                    batch.item[n] = bnt_pkg::mk_res(bnt_pkg::CH_MINUS, 8'd1,
                                                                    1'b0, bnt_pkg::ST_OK);
                                    n = n + 3'd1;
                                end
                                if (e_new[8])
                                begin
                                    batch.item[n] = bnt_pkg::mk_res(bnt_pkg::CH_ZERO, 8'd1,
                                                                    1'b0, bnt_pkg::ST_OK);
                                    n = n + 3'd1;
                                    batch.item[n] = bnt_pkg::mk_res(bnt_pkg::CH_POINT, 8'd1,
                                                                    1'b0, bnt_pkg::ST_OK);
                                    n = n + 3'd1;
                                    if (e_new < -9'sd1)
                                    begin
                                        batch.item[n] = bnt_pkg::mk_res(bnt_pkg::CH_ZERO,
                                            {rl[6:0], 1'b0}, 1'b0, bnt_pkg::ST_OK);
                                        n = n + 3'd1;
                                    end
                                end
                                pos_next = 5'd3;
                            end
                        end
                    end
                    default:
                    begin
                        if (neg_reg && {1'b0, pos_reg} >= {1'b0, len_reg} + 6'd1)
                        begin
                            fin = 1'b1;
                            if (byte_value != bnt_pkg::NEG_TERM)
                                fst = bnt_pkg::ST_NO_TERM;
                            else
                                fst = record_last ? bnt_pkg::ST_OK : bnt_pkg::ST_BAD_LEN;
                        end
                        else if (record_last && {1'b0, pos_reg} < {1'b0, len_reg} + 6'd1)
                        begin
                            fin = 1'b1;
                            fst = bnt_pkg::ST_BAD_LEN;
                        end
                        else
                        begin
                            if (idx <= e_cur)
                            begin
                                if (idx != 9'sd0 || tens != 4'd0)
                                begin
                                    batch.item[n] = bnt_pkg::mk_res(
                                        bnt_pkg::CH_ZERO + {3'b0, tens}, 8'd1, 1'b0,
                                        bnt_pkg::ST_OK);
                                    n = n + 3'd1;
                                end
                                batch.item[n] = bnt_pkg::mk_res(
                                    bnt_pkg::CH_ZERO + {3'b0, units}, 8'd1, 1'b0,
                                    bnt_pkg::ST_OK);
                                n = n + 3'd1;
                                if (idx == e_cur && idx < ndig - 9'sd1)
                                begin
                                    batch.item[n] = bnt_pkg::mk_res(bnt_pkg::CH_POINT, 8'd1,
                                                                    1'b0, bnt_pkg::ST_OK);
                                    n = n + 3'd1;
                                end
                            end
                            else
                            begin
                                batch.item[n] = bnt_pkg::mk_res(
                                    bnt_pkg::CH_ZERO + {3'b0, tens}, 8'd1, 1'b0,
                                    bnt_pkg::ST_OK);
                                n = n + 3'd1;
                                if (!(idx == ndig - 9'sd1 && units == 4'd0))
                                begin
                                    batch.item[n] = bnt_pkg::mk_res(
                                        bnt_pkg::CH_ZERO + {3'b0, units}, 8'd1, 1'b0,
                                        bnt_pkg::ST_OK);
                                    n = n + 3'd1;
                                end
                            end
                            if (idx >= ndig - 9'sd1)
                            begin
                                if (e_cur > idx)
                                begin
                                    batch.item[n] = bnt_pkg::mk_res(bnt_pkg::CH_ZERO,
                                        {rt[6:0], 1'b0}, 1'b0, bnt_pkg::ST_OK);
                                    n = n + 3'd1;
                                end
                                if (!neg_reg)
                                begin
                                    fin = 1'b1;
                                    fst = record_last ? bnt_pkg::ST_OK : bnt_pkg::ST_BAD_LEN;
                                end
                            end
                            if (!fin)
                                pos_next = pos_reg + 5'd1;
                        end
                    end
                endcase

                if (fin)
                begin
                    batch.item[n] = bnt_pkg::mk_res(bnt_pkg::CH_NONE, 8'd0, 1'b1, fst);
                    n = n + 3'd1;
                    if (record_last)
                    begin
                        pos_next    = '0;
                        len_next    = '0;
                        neg_next    = 1'b0;
                        exp_next    = '0;
                        failed_next = 1'b0;
                    end
                    else
                        failed_next = 1'b1;
                end
            end
        end
        batch.cnt = n;
    end

endmodule

### rtl/core/bnt_queue.sv
// bnt_queue: result queue that takes up to five runs per cycle while it has
// room and hands out one run per output transaction. Depends on bnt_pkg.
module bnt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  bnt_pkg::batch_t batch,
    input  logic            rd_ready,
    output logic            rd_valid,
    output bnt_pkg::res_t   rd_data,
    output logic            room
);

    localparam logic [bnt_pkg::QUEUE_AW:0] ROOM_LIMIT =
        (bnt_pkg::QUEUE_AW + 1)'(bnt_pkg::QUEUE_DEPTH - bnt_pkg::MAX_RES);

    bnt_pkg::res_t mem_reg [bnt_pkg::QUEUE_DEPTH];

    logic [bnt_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bnt_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bnt_pkg::QUEUE_AW:0]   cnt_reg, cnt_next;
    logic [2:0]                   n_wr;
    logic                         pop;

    assign n_wr     = wr_en ? batch.cnt : 3'd0;
    assign rd_valid = (cnt_reg != '0);
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign room     = (cnt_reg <= ROOM_LIMIT);

    assign wr_ptr_next = wr_ptr_reg + bnt_pkg::QUEUE_AW'(n_wr);
    assign rd_ptr_next = rd_ptr_reg + bnt_pkg::QUEUE_AW'(pop);
    assign cnt_next    = cnt_reg + (bnt_pkg::QUEUE_AW + 1)'(n_wr)
                       - (bnt_pkg::QUEUE_AW + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < bnt_pkg::MAX_RES; k++)
        begin
            if (3'(k) < n_wr)
                mem_reg[wr_ptr_reg + bnt_pkg::QUEUE_AW'(k)] <= batch.item[k];
        end
    end

endmodule

### rtl/core/bnt_checker.sv
// bnt_checker: port-level checks on the result channel, bound to the top
// level. Depends on bnt_pkg and base100_number_record_to_text.
module bnt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] char_code,
    input logic [7:0] repeat_res,
    input logic       end_of_number,
    input logic [1:0] status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code)
            && $stable(repeat_res) && $stable(end_of_number) && $stable(status))
        else $error("result changed while stalled");

    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_number |-> char_code == bnt_pkg::CH_NONE && repeat_res == 8'd0)
        else $error("end marker carries text");

    a_text_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_number |-> status == bnt_pkg::ST_OK && repeat_res != 8'd0
            && repeat_res <= 8'd128)
        else $error("bad text run");

    a_text_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_number |-> (char_code >= bnt_pkg::CH_ZERO
            && char_code <= bnt_pkg::CH_ZERO + 7'd9)
            || char_code == bnt_pkg::CH_MINUS || char_code == bnt_pkg::CH_POINT)
        else $error("bad character code");

endmodule

bind base100_number_record_to_text bnt_checker u_bnt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_code    (char_code),
    .repeat_res   (repeat_res),
    .end_of_number(end_of_number),
    .status       (status)
);

### tb/sv/base100_number_record_to_text_tb.sv
// Testbench for base100_number_record_to_text: feeds numeric records byte by
// byte, predicts every text run and end result, and checks them in order.
// Depends on bnt_pkg and the base100_number_record_to_text top level.
`timescale 1ns / 100ps

module base100_number_record_to_text_tb;

    localparam int MAX_RECORD_BYTES = 23;
    localparam int CYCLE_LIMIT      = 100000;
    localparam int DRAIN_CYCLES     = 16;

    typedef enum int {
        RX_STEADY,
        RX_CHOPPY,
        RX_LONG_STALLS
    } rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] byte_value = 8'd0;
    logic       record_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [6:0] char_code;
    logic [7:0] repeat_res;
    logic       end_of_number;
    logic [1:0] status;

    bnt_pkg::res_t    expected_runs[$];
    logic [4:0]       pos_q = 5'd0;
    logic [4:0]       len_q = 5'd0;
    bit               neg_q = 1'b0;
    logic signed [7:0] exp_q = 8'sd0;
    bit               dropping_q = 1'b0;

    int       error_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    bit       tx_bursty = 1'b0;
    rx_mode_t rx_mode = RX_STEADY;
    int       rx_hold = 0;
    int       random_bytes_sent = 0;

    base100_number_record_to_text #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_value   (byte_value),
        .record_last  (record_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .char_code    (char_code),
        .repeat_res   (repeat_res),
        .end_of_number(end_of_number),
        .status       (status)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("base100_number_record_to_text_tb failed");
            $finish;
        end
    end

    task automatic clear_record_state();
        pos_q      = 5'd0;
        len_q      = 5'd0;
        neg_q      = 1'b0;
        exp_q      = 8'sd0;
        dropping_q = 1'b0;
    endtask

    task automatic expect_run(input logic [6:0] ch, input int rep);
        bnt_pkg::res_t r;
        r.char_code     = ch;
        r.repeat_res    = 8'(rep);
        r.end_of_number = 1'b0;
        r.status        = bnt_pkg::ST_OK;
        expected_runs.push_back(r);
    endtask

    task automatic close_record(input bnt_pkg::status_t st, input bit last);
        bnt_pkg::res_t r;
        r.char_code     = bnt_pkg::CH_NONE;
        r.repeat_res    = 8'd0;
        r.end_of_number = 1'b1;
        r.status        = st;
        expected_runs.push_back(r);
        if (last)
            clear_record_state();
        else
            dropping_q = 1'b1;
    endtask

    task automatic decode_record_byte(input logic [7:0] b, input bit last);
        int e, i, ndig, d, tens, units, pos, len;
        bit neg, closed;
        pos    = pos_q;
        len    = len_q;
        closed = 1'b0;
        if (dropping_q)
        begin
            if (last)
                clear_record_state();
        end
        else if (pos == 0)
        begin
            if (b != bnt_pkg::TYPE_NUMBER)
                close_record(bnt_pkg::ST_BAD_TYPE, last);
            else if (last)
                close_record(bnt_pkg::ST_BAD_LEN, last);
            else
                pos_q = 5'd1;
        end
        else if (pos == 1)
        begin
            if (b == 0 || b > MAX_RECORD_BYTES - 2 || last)
                close_record(bnt_pkg::ST_BAD_LEN, last);
            else
            begin
                len_q = b[4:0];
                pos_q = 5'd2;
            end
        end
        else if (pos == 2)
        begin
            neg = (b < 128);
            e   = neg ? 62 - int'(b) : int'(b) - 193;
            if (neg && len < 3)
                close_record(bnt_pkg::ST_BAD_LEN, last);
            else
            begin
                neg_q = neg;
                exp_q = 8'(e);
                if (!neg && len == 1)
                begin
                    expect_run(bnt_pkg::CH_ZERO, 1);
                    close_record(last ? bnt_pkg::ST_OK : bnt_pkg::ST_BAD_LEN, last);
                end
                else if (last)
                    close_record(bnt_pkg::ST_BAD_LEN, last);
                else
                begin
                    if (neg)
                        expect_run(bnt_pkg::CH_MINUS, 1);
                    if (e < 0)
                    begin
                        expect_run(bnt_pkg::CH_ZERO, 1);
                        expect_run(bnt_pkg::CH_POINT, 1);
                        if (e < -1)
                            expect_run(bnt_pkg::CH_ZERO, 2 * (-1 - e));
                    end
                    pos_q = 5'd3;
                end
            end
        end
        else
        begin
            neg  = neg_q;
            e    = exp_q;
            i    = pos - 3;
            ndig = neg ? len - 2 : len - 1;
            if (neg && pos >= len + 1)
                close_record((b == bnt_pkg::NEG_TERM)
                             ? (last ? bnt_pkg::ST_OK : bnt_pkg::ST_BAD_LEN)
                             : bnt_pkg::ST_NO_TERM, last);
            else if (last && pos < len + 1)
                close_record(bnt_pkg::ST_BAD_LEN, last);
            else
            begin
                d = neg ? 101 - int'(b) : int'(b) - 1;
                if (d < 0)
                    d = 0;
                if (d > 99)
                    d = 99;
                tens  = d / 10;
                units = d % 10;
                if (i <= e)
                begin
                    if (i != 0 || tens != 0)
                        expect_run(bnt_pkg::CH_ZERO + 7'(tens), 1);
                    expect_run(bnt_pkg::CH_ZERO + 7'(units), 1);
                    if (i == e && i < ndig - 1)
                        expect_run(bnt_pkg::CH_POINT, 1);
                end
                else
                begin
                    expect_run(bnt_pkg::CH_ZERO + 7'(tens), 1);
                    if (!(i == ndig - 1 && units == 0))
                        expect_run(bnt_pkg::CH_ZERO + 7'(units), 1);
                end
                if (i >= ndig - 1)
                begin
                    if (e > i)
                        expect_run(bnt_pkg::CH_ZERO, 2 * (e - i));
                    if (!neg)
                    begin
                        close_record(last ? bnt_pkg::ST_OK : bnt_pkg::ST_BAD_LEN, last);
                        closed = 1'b1;
                    end
                end
                if (!closed)
                    pos_q = pos_q + 5'd1;
            end
        end
    endtask

    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            decode_record_byte(byte_value, record_last);

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        bnt_pkg::res_t r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_runs.size() == 0)
                report_mismatch($sformatf("run ch=%h rep=%0d end=%b st=%0d with none expected",
                                          char_code, repeat_res, end_of_number, status));
            else
            begin
                r = expected_runs.pop_front();
                if (char_code !== r.char_code)
                    report_mismatch($sformatf("char_code %h, want %h", char_code, r.char_code));
                if (repeat_res !== r.repeat_res)
                    report_mismatch($sformatf("repeat_res %0d, want %0d",
                                              repeat_res, r.repeat_res));
                if (end_of_number !== r.end_of_number)
                    report_mismatch($sformatf("end_of_number %b, want %b",
                                              end_of_number, r.end_of_number));
                if (status !== r.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, r.status));
            end
        end
    end

    // stall the result side according to the current mode
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
        begin
            case (rx_mode)
                RX_STEADY:
                    out_ready <= 1'b1;
                RX_CHOPPY:
                    out_ready <= ($urandom_range(0, 2) != 0);
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        rx_hold = $urandom_range(4, 24);
                        out_ready <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
                end
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit last);
        if (tx_bursty && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        in_valid    <= 1'b1;
        byte_value  <= b;
        record_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic test_zero_value();
        send_byte(bnt_pkg::TYPE_NUMBER, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'd255, 1'b1);
    endtask

    task automatic test_wrong_type();
        send_byte(8'd0, 1'b0);
        // drop the rest of the record after the error
        send_byte(8'd255, 1'b0);
        send_byte(8'd7, 1'b0);
        send_byte(bnt_pkg::TYPE_NUMBER, 1'b1);
    endtask

    task automatic test_bad_length();
        send_byte(bnt_pkg::TYPE_NUMBER, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd9, 1'b1);
        send_byte(bnt_pkg::TYPE_NUMBER, 1'b0);
        send_byte(8'(MAX_RECORD_BYTES - 1), 1'b1);
    endtask

    task automatic test_negative_terminator();
        send_byte(bnt_pkg::TYPE_NUMBER, 1'b0);
        send_byte(8'd3, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd100, 1'b0);
        send_byte(8'd5, 1'b1);
        send_byte(bnt_pkg::TYPE_NUMBER, 1'b0);
        send_byte(8'd3, 1'b0);
        send_byte(8'd127, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(bnt_pkg::NEG_TERM, 1'b1);
    endtask

    task automatic test_out_of_range_pairs();
        send_byte(bnt_pkg::TYPE_NUMBER, 1'b0);
        send_byte(8'd3, 1'b0);
        send_byte(8'd193, 1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(8'd0, 1'b1);
    endtask

    task automatic send_random_record();
        logic [7:0] rec[$];
        int  kind, len, e, pair, cut, k;
        bit  neg, keep_last;
        kind = $urandom_range(0, 99);
        neg  = $urandom_range(0, 1);
        if ($urandom_range(0, 15) == 0)
            len = $urandom_range(7, MAX_RECORD_BYTES - 2);
        else
            len = neg ? $urandom_range(3, 6) : $urandom_range(1, 5);
        e = $urandom_range(0, 7) - 3;
        rec.push_back(bnt_pkg::TYPE_NUMBER);
        rec.push_back(8'(len));
        if ($urandom_range(0, 7) == 0)
            rec.push_back(neg ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255)));
        else
            rec.push_back(neg ? 8'(62 - e) : 8'(193 + e));
        for (k = 0; k < (neg ? len - 2 : len - 1); k++)
        begin
            pair = ($urandom_range(0, 3) == 0) ? 10 * $urandom_range(0, 9)
                                                : $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                rec.push_back(8'($urandom_range(0, 255)));
            else
                rec.push_back(neg ? 8'(101 - pair) : 8'(pair + 1));
        end
        if (neg)
            rec.push_back(bnt_pkg::NEG_TERM);
        keep_last = 1'b1;
        if (kind >= 95)
        begin
            rec.delete();
            repeat ($urandom_range(1, 6)) rec.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind >= 90)
        begin
            if (neg)
                rec[rec.size() - 1] = 8'($urandom_range(0, 101));
            else
                keep_last = 1'b0;
        end
        else if (kind >= 85)
            keep_last = 1'b0;
        else if (kind >= 80)
        begin
            cut = $urandom_range(1, rec.size() - 1);
            while (rec.size() > cut)
                void'(rec.pop_back());
        end
        else if (kind >= 75)
        begin
            if (neg && $urandom_range(0, 1))
                rec[1] = 8'($urandom_range(1, 2));
            else
                rec[1] = $urandom_range(0, 1) ? 8'd0
                                              : 8'($urandom_range(MAX_RECORD_BYTES - 1, 255));
        end
        else if (kind >= 70)
        begin
            rec[0] = 8'($urandom_range(0, 255));
            if (rec[0] == bnt_pkg::TYPE_NUMBER)
                rec[0] = ~bnt_pkg::TYPE_NUMBER;
        end
        for (k = 0; k < rec.size(); k++)
            send_byte(rec[k], keep_last && k == rec.size() - 1);
        if (!keep_last)
        begin
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        random_bytes_sent += rec.size();
    endtask

    task automatic test_random_records(input int byte_budget, input bit bursty,
                                       input rx_mode_t mode);
        int target;
        tx_bursty = bursty;
        rx_mode   = mode;
        target    = random_bytes_sent + byte_budget;
        while (random_bytes_sent < target)
            send_random_record();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_bursty = 1'b1;
        rx_mode   = RX_CHOPPY;
        test_zero_value();
        test_wrong_type();
        test_bad_length();
        test_negative_terminator();
        test_out_of_range_pairs();

        test_random_records(25, 1'b0, RX_STEADY);
        test_random_records(25, 1'b1, RX_CHOPPY);
        test_random_records(25, 1'b1, RX_LONG_STALLS);

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("base100_number_record_to_text_tb passed");
        else
            $display("base100_number_record_to_text_tb failed");
        $finish;
    end

endmodule
